FILE: src/qbsaw_pkg.sv
// ----------------------------------------------------------------------------
// qbsaw_pkg
// Shared types and constants of the quasi-bandlimited sawtooth oscillator.
// ----------------------------------------------------------------------------
package qbsaw_pkg;

  localparam int PHASE_BITS = 24;
  localparam int FRAC_BITS  = 15;
  localparam int FREQ_W     = 24;
  localparam int FILT_W     = 16;
  localparam int OUT_W      = FRAC_BITS + 4;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 28;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic signed [MUL_A_W-1:0] coef_t;

  // odd sine polynomial in Q.30, Horner order after the ninth power term
  localparam coef_t SIN_C9 = 36'sd88203476;
  localparam coef_t SIN_HORNER [4] = '{
    -36'sd643455388,
    36'sd2738217788,
    -36'sd5548789346,
    36'sd3373259426
  };

  // output scaling: y = floor(n / (125 * 2^16)) with n offset for round half up
  localparam longint OUT_ROUND  = 64'sd4096000;
  localparam longint DIV_LIMIT  = 64'sd20480000;
  localparam coef_t  RECIP_125  = 36'sd68719477;
  localparam int     RECIP_SHIFT = 33;
  localparam logic signed [OUT_W-1:0] OUT_OFFSET = 19'sd163840;

endpackage

FILE: src/qbsaw_if.sv
// ----------------------------------------------------------------------------
// qbsaw_in_if / qbsaw_out_if
// Valid/ready channels carrying oscillator requests and output samples.
// ----------------------------------------------------------------------------
interface qbsaw_in_if import qbsaw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FREQ_W-1:0]        freq_norm;
  logic signed [FILT_W-1:0] filter_amount;

  modport source (output valid, freq_norm, filter_amount, input ready);
  modport sink (input valid, freq_norm, filter_amount, output ready);
endinterface

interface qbsaw_out_if import qbsaw_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

FILE: src/qbsaw_mul.sv
// ----------------------------------------------------------------------------
// qbsaw_mul
// Shared signed multiplier with a registered product, held when not enabled.
// ----------------------------------------------------------------------------
module qbsaw_mul import qbsaw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

FILE: src/quasi_bandlimited_saw_oscillator.sv
// ----------------------------------------------------------------------------
// quasi_bandlimited_saw_oscillator
// Feedback-sine sawtooth oscillator, one output sample per request.
// ----------------------------------------------------------------------------
// Each request (normalized frequency, filter amount) yields one sample in the
// output register: a small sequencer drives one shared registered multiplier
// through the shaping coefficient, the feedback term, a four-step Horner sine
// evaluation (each step split into two partial products) and the final gain
// and divide-by-constant. The input is ready again once the sample has moved
// into the output register, when the sequencer returns to idle, so a new
// request is taken only after the last one is through. A waiting sample does
// not block a new request; only a sample that is still waiting when the next
// one is finished holds the sequencer in its last step.
module quasi_bandlimited_saw_oscillator import qbsaw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  qbsaw_in_if.sink    in_i,
  qbsaw_out_if.source out_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_H2, S_H4, S_B, S_BZ, S_ARG, S_SQ, S_X2,
    S_HI, S_LO, S_ADD, S_SX, S_Z, S_ACC, S_Y, S_Q
  } state_e;

  state_e state_q;

  logic [PHASE_BITS-1:0]      phase_q;
  logic [15:0]                wf_q;
  logic signed [FILT_W-1:0]   filt_q;
  logic signed [15:0]         fn_q, fp_q, z0_q;
  logic signed [16:0]         a_q;
  logic [28:0]                x2_q;
  coef_t                      t_q;
  logic signed [63:0]         hacc_q;
  logic [1:0]                 k_q;
  logic signed [OUT_W-1:0]    out_q;
  logic                       out_valid_q;

  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod;

  logic [16:0]                wf_sum;
  logic signed [16:0]         h;
  logic signed [63:0]         rnd15;
  logic [13:0]                h2;
  logic [11:0]                h4;
  logic [15:0]                h4x13;
  logic signed [15:0]         p_val, bz;
  logic signed [16:0]         a_sum;
  logic signed [15:0]         a_wrap;
  logic signed [16:0]         a_fold;
  logic signed [63:0]         hsum;
  logic signed [63:0]         s1, s2;
  logic signed [16:0]         s_c;
  logic signed [17:0]         z_sum;
  logic signed [15:0]         z_new;
  logic signed [31:0]         acc;
  logic signed [17:0]         gain;
  logic signed [63:0]         n_div, n_clamp;
  logic signed [27:0]         u_div;
  logic signed [OUT_W-1:0]    y_val;
  logic                       out_free;

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_q;
  assign out_free         = !out_valid_q || out_o.ready;

  // frequency rounding and shaping base
  assign wf_sum = {1'b0, in_i.freq_norm[23:8]} + 17'd1;
  assign h      = 17'sd16384 - $signed({1'b0, wf_q});

  // shared rounding of Q.F products
  assign rnd15 = prod + 64'sd16384;
  assign h2    = rnd15[28:15];
  assign h4    = rnd15[26:15];
  assign h4x13 = {h4, 4'b0} - {3'b0, h4, 1'b0} - {4'b0, h4};

  // sine argument: phase plus feedback, wrapped then folded
  assign p_val  = {~phase_q[23], phase_q[22:9], 1'b0};
  assign bz     = rnd15[30:15];
  assign a_sum  = 17'(p_val) + 17'(bz);
  assign a_wrap = a_sum[15:0];
  always_comb begin
    if (a_wrap > 16'sd16384) begin
      a_fold = 17'sd32768 - 17'(a_wrap);
    end else if (a_wrap < -16'sd16384) begin
      a_fold = -17'sd32768 - 17'(a_wrap);
    end else begin
      a_fold = 17'(a_wrap);
    end
  end

  // horner accumulate with Q.30 rounding
  assign hsum = hacc_q + prod + 64'sd536870912;

  // sine result, feedback update
  assign s1 = rnd15 >>> 15;
  assign s2 = (s1 + 64'sd16384) >>> 15;
  always_comb begin
    if (s2 > 64'sd32768) begin
      s_c = 17'sd32768;
    end else if (s2 < -64'sd32768) begin
      s_c = -17'sd32768;
    end else begin
      s_c = s2[16:0];
    end
    z_sum = (18'(fn_q) + 18'(s_c) + 18'sd1) >>> 1;
    if (z_sum > 18'sd32767) begin
      z_new = 16'sd32767;
    end else if (z_sum < -18'sd32768) begin
      z_new = -16'sd32768;
    end else begin
      z_new = z_sum[15:0];
    end
  end

  // output polynomial and gain
  assign acc  = 32'sd125 * (32'sd5 * 32'(z0_q) - 32'sd3 * 32'(fp_q))
              + 32'sd3080192 - 32'sd188 * $signed({16'b0, wf_q});
  assign gain = 18'sd32768 - $signed({1'b0, wf_q, 1'b0});

  // clamp before dividing by 125
  always_comb begin
    n_div = (prod + OUT_ROUND) >>> 16;
    if (n_div < -DIV_LIMIT) begin
      n_clamp = -DIV_LIMIT;
    end else if (n_div > DIV_LIMIT - 64'sd1) begin
      n_clamp = DIV_LIMIT - 64'sd1;
    end else begin
      n_clamp = n_div;
    end
  end
  assign u_div = 28'(n_clamp + DIV_LIMIT);
  assign y_val = OUT_W'(prod >>> RECIP_SHIFT) - OUT_OFFSET;

  // multiplier operand select
  always_comb begin
    mul_en = (state_q != S_Q);
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_H2: begin
        mul_a = MUL_A_W'(h);
        mul_b = MUL_B_W'(h);
      end
      S_H4: begin
        mul_a = MUL_A_W'($signed({1'b0, h2}));
        mul_b = MUL_B_W'($signed({1'b0, h2}));
      end
      S_B: begin
        mul_a = MUL_A_W'($signed({1'b0, h4x13}));
        mul_b = MUL_B_W'(filt_q);
      end
      S_BZ: begin
        mul_a = MUL_A_W'(bz);
        mul_b = MUL_B_W'(fn_q);
      end
      S_SQ: begin
        mul_a = MUL_A_W'(a_q);
        mul_b = MUL_B_W'(a_q);
      end
      S_HI: begin
        mul_a = t_q;
        mul_b = MUL_B_W'($signed({1'b0, x2_q[28:15]}));
      end
      S_LO: begin
        mul_a = t_q;
        mul_b = MUL_B_W'($signed({1'b0, x2_q[14:0]}));
      end
      S_SX: begin
        mul_a = t_q;
        mul_b = MUL_B_W'(a_q);
      end
      S_ACC: begin
        mul_a = MUL_A_W'(gain);
        mul_b = acc[MUL_B_W-1:0];
      end
      S_Y: begin
        mul_a = RECIP_125;
        mul_b = u_div;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  qbsaw_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      wf_q        <= '0;
      filt_q      <= '0;
      fn_q        <= '0;
      fp_q        <= '0;
      z0_q        <= '0;
      a_q         <= '0;
      x2_q        <= '0;
      t_q         <= '0;
      hacc_q      <= '0;
      k_q         <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output handshake
      if (state_q == S_Q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            wf_q    <= wf_sum[16:1];
            filt_q  <= in_i.filter_amount;
            phase_q <= phase_q + PHASE_BITS'(in_i.freq_norm);
            state_q <= S_H2;
          end
        end
        S_H2:  state_q <= S_H4;
        S_H4:  state_q <= S_B;
        S_B:   state_q <= S_BZ;
        S_BZ:  state_q <= S_ARG;
        S_ARG: begin
          a_q     <= a_fold;
          state_q <= S_SQ;
        end
        S_SQ:  state_q <= S_X2;
        S_X2: begin
          x2_q    <= prod[28:0];
          t_q     <= SIN_C9;
          k_q     <= '0;
          state_q <= S_HI;
        end
        S_HI:  state_q <= S_LO;
        S_LO: begin
          hacc_q  <= prod <<< 15;
          state_q <= S_ADD;
        end
        S_ADD: begin
          t_q     <= SIN_HORNER[k_q] + MUL_A_W'($signed(hsum[63:30]));
          k_q     <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? S_SX : S_HI;
        end
        S_SX:  state_q <= S_Z;
        S_Z: begin
          z0_q    <= z_new;
          state_q <= S_ACC;
        end
        S_ACC: begin
          fn_q    <= z0_q;
          fp_q    <= z0_q;
          state_q <= S_Y;
        end
        S_Y:   state_q <= S_Q;
        S_Q: begin
          if (out_free) begin
            out_q   <= y_val;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
